// ===== hw/rtl/bqpm_pkg.sv =====
package bqpm_pkg;

   localparam int unsigned POS_W  = 16;
   localparam int unsigned CHAR_W = 8;

   typedef enum logic [1:0] {
      KIND_PAREN  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_BRACE  = 2'd2,
      KIND_QUOTE  = 2'd3
   } kind_type;

   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      kind_type         kind;
      logic [POS_W-1:0] pos;
   } entry_type;

   typedef struct packed {
      logic [POS_W-1:0] open_pos;
      logic [POS_W-1:0] close_pos;
      kind_type         pair_kind;
      logic             overflow;
   } result_type;

endpackage

// ===== hw/rtl/bqpm_stack.sv =====
module bqpm_stack #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  bqpm_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output bqpm_pkg::entry_type rd_data
);
   import bqpm_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // A read of the entry being written returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bqpm_out_buf.sv =====
module bqpm_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bqpm_pkg::result_type in_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output bqpm_pkg::result_type out_data
);
   import bqpm_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       taken;

   assign taken = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (taken) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || taken) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== hw/rtl/bracket_quote_pair_matcher_core.sv =====
// Bracket and quote pair matcher.
// One text character is taken per request on the req_ channel; req_start_text
// marks the first character of a new text and clears the stack and position.
// Each request gives at most one response on the rsp_ channel: a matched pair
// with its open and close positions and kind, or a dropped opener flagged by
// rsp_overflow with both positions zero.
// Throughput is one request per cycle while req_stall is low. The stack
// top is read from a memory with a registered read port whose address
// follows the next stack count, so every request sees its top of stack
// without waiting. A response is registered before it appears on rsp_valid.
// The response register is backed by a one-entry skid stage, so requests keep
// being taken while a response waits; req_stall rises only when both are
// occupied and falls as soon as the receiver takes a response.
// Reset clears the stack count, position, escape flag and the response
// channel; the stack memory needs no clearing pass, as an entry is used only
// after it has been written.
module bracket_quote_pair_matcher_core #(
   parameter int unsigned MAX_LEN     = 65536,
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_start_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_open_pos,
   output logic [15:0] rsp_close_pos,
   output logic [1:0]  rsp_pair_kind,
   output logic        rsp_overflow
);
   import bqpm_pkg::*;

   localparam int unsigned IDX_W  = $clog2(MAX_LEN);
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [CNT_W-1:0] count_ff, count_in, count_eff;
   logic [IDX_W-1:0] idx_ff, idx_in, idx_eff;
   logic             skip_ff, skip_in, skip_eff;

   logic             accept;
   logic             out_full;
   entry_type        top;
   entry_type        push_entry;
   logic             push, pop;
   logic             res_valid;
   result_type       res;
   result_type       rsp_data;
   logic [POS_W-1:0] pos;
   logic             nonempty, full_stack, in_quote;
   logic             is_open, is_close;
   kind_type         ch_kind;
   logic [ADDR_W-1:0] rd_addr;

   assign req_stall = out_full;
   assign accept    = req_valid && !out_full;

   assign count_eff = req_start_text ? '0 : count_ff;
   assign idx_eff   = req_start_text ? '0 : idx_ff;
   assign skip_eff  = req_start_text ? 1'b0 : skip_ff;
   assign pos       = POS_W'(idx_eff);

   assign nonempty   = (count_eff != '0);
   assign full_stack = (count_eff == CNT_W'(STACK_DEPTH));
   assign in_quote   = nonempty && (top.kind == KIND_QUOTE);

   always_comb begin
      is_open  = 1'b0;
      is_close = 1'b0;
      ch_kind  = KIND_PAREN;
      case (req_ch)
         CH_LPAREN: begin
            is_open = 1'b1;
            ch_kind = KIND_PAREN;
         end
         CH_LSQUARE: begin
            is_open = 1'b1;
            ch_kind = KIND_SQUARE;
         end
         CH_LBRACE: begin
            is_open = 1'b1;
            ch_kind = KIND_BRACE;
         end
         CH_DQUOTE: begin
            is_open = 1'b1;
            ch_kind = KIND_QUOTE;
         end
         CH_RPAREN: begin
            is_close = 1'b1;
            ch_kind  = KIND_PAREN;
         end
         CH_RSQUARE: begin
            is_close = 1'b1;
            ch_kind  = KIND_SQUARE;
         end
         CH_RBRACE: begin
            is_close = 1'b1;
            ch_kind  = KIND_BRACE;
         end
         default: begin
            is_open  = 1'b0;
            is_close = 1'b0;
         end
      endcase
   end

   always_comb begin
      push          = 1'b0;
      pop           = 1'b0;
      res_valid     = 1'b0;
      res.open_pos  = top.pos;
      res.close_pos = pos;
      res.pair_kind = ch_kind;
      res.overflow  = 1'b0;
      skip_in       = skip_eff;
      if (skip_eff) begin
         skip_in = 1'b0;
      end else if (in_quote) begin
         if (req_ch == CH_BSLASH) begin
            skip_in = 1'b1;
         end else if (req_ch == CH_DQUOTE) begin
            pop           = 1'b1;
            res_valid     = 1'b1;
            res.pair_kind = KIND_QUOTE;
         end
      end else if (is_open) begin
         if (!full_stack) begin
            push = 1'b1;
         end else begin
            res_valid     = 1'b1;
            res.open_pos  = '0;
            res.close_pos = '0;
            res.overflow  = 1'b1;
         end
      end else if (is_close && nonempty && (top.kind == ch_kind)) begin
         pop       = 1'b1;
         res_valid = 1'b1;
      end
   end

   assign idx_in = (idx_eff == IDX_W'(MAX_LEN - 1)) ? '0 : idx_eff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (push) begin
            count_in = count_eff + 1'b1;
         end else if (pop) begin
            count_in = count_eff - 1'b1;
         end else begin
            count_in = count_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         skip_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            idx_ff  <= idx_in;
            skip_ff <= skip_in;
         end
      end
   end

   assign push_entry.kind = ch_kind;
   assign push_entry.pos  = pos;
   assign rd_addr         = ADDR_W'(count_in - 1'b1);

   bqpm_stack #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (accept && push),
      .wr_addr (ADDR_W'(count_eff)),
      .wr_data (push_entry),
      .rd_addr (rd_addr),
      .rd_data (top)
   );

   bqpm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && res_valid),
      .in_data   (res),
      .full      (out_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_open_pos  = rsp_data.open_pos;
   assign rsp_close_pos = rsp_data.close_pos;
   assign rsp_pair_kind = rsp_data.pair_kind;
   assign rsp_overflow  = rsp_data.overflow;

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_stall_means_pending : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_overflow_no_pos : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_open_pos == '0 && rsp_close_pos == '0))
      else $error("overflow response carries positions");

   a_full_push_flags : assert property (@(posedge clock) disable iff (reset)
      (accept && is_open && !skip_eff && !in_quote && full_stack) |=> rsp_valid)
      else $error("dropped opener gave no response");

endmodule

// ===== bench/tb_bracket_quote_pair_matcher_core.sv =====
`timescale 1ns / 100ps

module tb_bracket_quote_pair_matcher_core;
   import bqpm_pkg::*;

   localparam int STACK_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1100;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 3_000_000;

   typedef struct {
      logic [7:0] ch;
      logic       st;
      int         reps;
      bit         typed;
      result_type want;
   } step_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        req_start_text;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_open_pos;
   logic [15:0] rsp_close_pos;
   logic [1:0]  rsp_pair_kind;
   logic        rsp_overflow;

   kind_type    open_kind_stack [STACK_DEPTH];
   logic [15:0] open_pos_stack [STACK_DEPTH];
   int          open_depth = 0;
   logic [15:0] text_pos = '0;
   bit          skip_next = 1'b0;

   result_type  pending_pairs [$];
   step_type    script [$];
   int          mismatch_count = 0;
   int          cycles = 0;
   int          rsp_wait = 0;
   bit          rsp_calm = 1'b0;
   logic [7:0]  opener_char [4] = '{CH_LPAREN, CH_LSQUARE, CH_LBRACE, CH_DQUOTE};
   logic [7:0]  closer_char [4] = '{CH_RPAREN, CH_RSQUARE, CH_RBRACE, CH_DQUOTE};

   bracket_quote_pair_matcher_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_start_text (req_start_text),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_open_pos   (rsp_open_pos),
      .rsp_close_pos  (rsp_close_pos),
      .rsp_pair_kind  (rsp_pair_kind),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit match_char(input logic [7:0] c, input logic st,
                                     output result_type r);
      logic [15:0] pos;
      kind_type    k;
      bit          opener;
      bit          closer;
      r = '0;
      k = KIND_PAREN;
      opener = 1'b1;
      closer = 1'b0;
      if (st) begin
         open_depth = 0;
         text_pos = '0;
         skip_next = 1'b0;
      end
      pos = text_pos;
      text_pos = text_pos + 16'd1;
      if (skip_next) begin
         skip_next = 1'b0;
         return 1'b0;
      end
      if (open_depth > 0 && open_kind_stack[open_depth-1] == KIND_QUOTE) begin
         if (c == CH_BSLASH) begin
            skip_next = 1'b1;
         end else if (c == CH_DQUOTE) begin
            open_depth--;
            r.open_pos = open_pos_stack[open_depth];
            r.close_pos = pos;
            r.pair_kind = KIND_QUOTE;
            return 1'b1;
         end
         return 1'b0;
      end
      case (c)
         CH_LPAREN:  k = KIND_PAREN;
         CH_LSQUARE: k = KIND_SQUARE;
         CH_LBRACE:  k = KIND_BRACE;
         CH_DQUOTE:  k = KIND_QUOTE;
         CH_RPAREN: begin
            k = KIND_PAREN;
            opener = 1'b0;
            closer = 1'b1;
         end
         CH_RSQUARE: begin
            k = KIND_SQUARE;
            opener = 1'b0;
            closer = 1'b1;
         end
         CH_RBRACE: begin
            k = KIND_BRACE;
            opener = 1'b0;
            closer = 1'b1;
         end
         default: opener = 1'b0;
      endcase
      if (opener) begin
         if (open_depth < STACK_DEPTH) begin
            open_kind_stack[open_depth] = k;
            open_pos_stack[open_depth] = pos;
            open_depth++;
            return 1'b0;
         end
         r.pair_kind = k;
         r.overflow = 1'b1;
         return 1'b1;
      end
      if (closer && open_depth > 0 && open_kind_stack[open_depth-1] == k) begin
         open_depth--;
         r.open_pos = open_pos_stack[open_depth];
         r.close_pos = pos;
         r.pair_kind = k;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void plain(input logic [7:0] c, input logic st, input int reps);
      step_type s;
      s.ch = c;
      s.st = st;
      s.reps = reps;
      s.typed = 1'b0;
      s.want = '0;
      script.push_back(s);
   endfunction

   function automatic void paired(input logic [7:0] c, input logic st,
                                  input logic [15:0] o, input logic [15:0] cl,
                                  input kind_type k, input logic ovf);
      step_type s;
      s.ch = c;
      s.st = st;
      s.reps = 1;
      s.typed = 1'b1;
      s.want.open_pos = o;
      s.want.close_pos = cl;
      s.want.pair_kind = k;
      s.want.overflow = ovf;
      script.push_back(s);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic st, input int gap,
                            input bit typed, input result_type want);
      result_type got;
      bit         hit;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_start_text <= st;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hit = match_char(c, st, got);
      if (typed) begin
         pending_pairs.push_back(want);
      end else if (hit) begin
         pending_pairs.push_back(got);
      end
   endtask

   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_calm = ~rsp_calm;
         end
         w = rsp_calm ? 0 : $urandom_range(0, 10);
         rsp_wait <= w;
         rsp_stall <= (w != 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end
   end

   always @(posedge clock) begin
      result_type exp_pair;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected response: open_pos %0d close_pos %0d kind %0d overflow %0d",
                   rsp_open_pos, rsp_close_pos, rsp_pair_kind, rsp_overflow);
            mismatch_count++;
         end else begin
            exp_pair = pending_pairs.pop_front();
            if (rsp_open_pos !== exp_pair.open_pos) begin
               $error("open_pos: expected %0d, got %0d", exp_pair.open_pos, rsp_open_pos);
               mismatch_count++;
            end
            if (rsp_close_pos !== exp_pair.close_pos) begin
               $error("close_pos: expected %0d, got %0d", exp_pair.close_pos,
                      rsp_close_pos);
               mismatch_count++;
            end
            if (rsp_pair_kind !== exp_pair.pair_kind) begin
               $error("pair_kind: expected %0d, got %0d", exp_pair.pair_kind,
                      rsp_pair_kind);
               mismatch_count++;
            end
            if (rsp_overflow !== exp_pair.overflow) begin
               $error("overflow: expected %0d, got %0d", exp_pair.overflow, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_bracket_quote_pair_matcher_core failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] c;
      logic       st;
      int         roll;
      int         burst;
      bit         calm;
      step_type   s;
      burst = 0;
      calm = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_ch <= '0;
      req_start_text <= 1'b0;

      plain(CH_LPAREN, 1'b1, 1);
      paired(CH_RPAREN, 1'b0, 16'd0, 16'd1, KIND_PAREN, 1'b0);
      plain(CH_RSQUARE, 1'b0, 1);
      plain(CH_LSQUARE, 1'b0, 1);
      plain(CH_RBRACE, 1'b0, 1);
      paired(CH_RSQUARE, 1'b0, 16'd3, 16'd5, KIND_SQUARE, 1'b0);
      plain(CH_LBRACE, 1'b0, 1);
      plain(CH_DQUOTE, 1'b0, 1);
      plain(CH_RPAREN, 1'b0, 1);
      plain(CH_BSLASH, 1'b0, 1);
      plain(CH_DQUOTE, 1'b0, 1);
      plain(8'h00, 1'b0, 1);
      paired(CH_DQUOTE, 1'b0, 16'd7, 16'd12, KIND_QUOTE, 1'b0);
      paired(CH_RBRACE, 1'b0, 16'd6, 16'd13, KIND_BRACE, 1'b0);
      plain(8'hFF, 1'b0, 1);
      plain(CH_BSLASH, 1'b0, 1);
      plain(CH_RPAREN, 1'b0, 1);
      plain(CH_LPAREN, 1'b1, STACK_DEPTH);
      paired(CH_LSQUARE, 1'b0, 16'd0, 16'd0, KIND_SQUARE, 1'b1);
      paired(CH_DQUOTE, 1'b0, 16'd0, 16'd0, KIND_QUOTE, 1'b1);
      paired(CH_LBRACE, 1'b0, 16'd0, 16'd0, KIND_BRACE, 1'b1);
      paired(CH_LPAREN, 1'b0, 16'd0, 16'd0, KIND_PAREN, 1'b1);
      paired(CH_RPAREN, 1'b0, 16'd63, 16'd68, KIND_PAREN, 1'b0);
      plain(CH_DQUOTE, 1'b1, 1);
      plain(CH_BSLASH, 1'b0, 1);
      plain(CH_DQUOTE, 1'b1, 1);
      paired(CH_DQUOTE, 1'b0, 16'd0, 16'd1, KIND_QUOTE, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[n]) begin
         s = script[n];
         for (int r = 0; r < s.reps; r++) begin
            send_char(s.ch, (r == 0) ? s.st : 1'b0,
                      (s.reps > 1) ? 0 : $urandom_range(0, 10), s.typed, s.want);
         end
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         if (i == RANDOM_ITEMS / 2) begin
            // Hold off new requests until the response channel has drained.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_pairs.size() != 0) @(posedge clock);
         end
         st = 1'b0;
         roll = $urandom_range(0, 99);
         if (burst > 0) begin
            burst--;
            c = opener_char[$urandom_range(0, 2)];
         end else if (roll < 2) begin
            st = 1'b1;
            c = 8'($urandom_range(0, 255));
         end else if (roll == 2) begin
            burst = STACK_DEPTH + 3;
            c = CH_LPAREN;
         end else if (open_depth > 0 && open_kind_stack[open_depth-1] == KIND_QUOTE) begin
            if (roll < 35) begin
               c = CH_DQUOTE;
            end else if (roll < 50) begin
               c = CH_BSLASH;
            end else begin
               c = 8'($urandom_range(0, 255));
            end
         end else if (roll < 30) begin
            c = opener_char[$urandom_range(0, 3)];
         end else if (roll < 60 && open_depth > 0) begin
            c = closer_char[open_kind_stack[open_depth-1]];
         end else if (roll < 70) begin
            c = closer_char[$urandom_range(0, 2)];
         end else begin
            c = 8'($urandom_range(0, 255));
         end
         send_char(c, st, calm ? 0 : $urandom_range(0, 10), 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pairs.size() == 0) begin
         $display("tb_bracket_quote_pair_matcher_core passed");
      end else begin
         $display("tb_bracket_quote_pair_matcher_core failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bqpm_pkg.sv
hw/rtl/bqpm_stack.sv
hw/rtl/bqpm_out_buf.sv
hw/rtl/bracket_quote_pair_matcher_core.sv
bench/tb_bracket_quote_pair_matcher_core.sv
